### design/utf8_sentence_splitter_macros.svh
// assertion macros for the sentence splitter, included by the output side module
`ifndef UTF8_SENTENCE_SPLITTER_MACROS_SVH
`define UTF8_SENTENCE_SPLITTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define USS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sentence splitter check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define USS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sentence splitter check failed");

`endif

### design/uss_pkg.sv
// shared types, character constants and decode functions for the sentence splitter
`timescale 1ns / 1ps

package uss_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       tok_start;
    logic       sent_end;
    logic       str_done;
    logic       bad;
  } res_t;

  localparam int QDEPTH = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EXCL  = 8'h21;

  // character length from a lead byte, zero for a stray or invalid byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    return (b < 8'hC0) ? 3'd0 :
           (b < 8'hE0) ? 3'd2 :
           (b < 8'hF0) ? 3'd3 :
           (b < 8'hF8) ? 3'd4 :
           (b < 8'hFC) ? 3'd5 :
           (b < 8'hFE) ? 3'd6 : 3'd0;
  endfunction

  // full-width sentence marks, all three bytes long
  function automatic logic is_punct(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2);
    return (b0 == 8'hE3 && b1 == 8'h80 && b2 == 8'h82) ||
           (b0 == 8'hEF && b1 == 8'hB9 && (b2 == 8'h94 || b2 == 8'h96)) ||
           (b0 == 8'hEF && b1 == 8'hBC &&
            (b2 == 8'h81 || b2 == 8'h9F || b2 == 8'h9B));
  endfunction

endpackage

### design/utf8_sentence_splitter.sv
// top level of the utf8 sentence splitter: front end, group queue, output side
//
//   channel   direction  handshake           beat
//   in_       input      in_push / in_full   one text byte and its end-of-string mark
//   out_      output     out_pop / out_empty one byte or status with token and sentence marks
//
// one input byte is taken per cycle while the group queue has room (4 groups)
// a finished n-byte character leaves the output register as n beats, one per cycle on out_pop
// a closed group goes into the queue, then its first beat into the output register
// rst_n is synchronous; reset empties the queue and the output register at once
// a stalled output fills the queue, then in_full holds off new bytes
`timescale 1ns / 1ps

module utf8_sentence_splitter #(
  parameter int MAX_CHAR_BYTES = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_token_start,
  output logic       out_sentence_end,
  output logic       out_string_done,
  output logic       out_bad_utf8
);
  import uss_pkg::*;

  localparam int CNT_W = $clog2(MAX_CHAR_BYTES) + 1;

  logic                         accept;
  logic                         ent_push;
  logic [CNT_W-1:0]             ent_cnt;
  res_t [MAX_CHAR_BYTES-1:0]    ent_res;
  logic                         head_valid;
  logic [CNT_W-1:0]             head_cnt;
  res_t [MAX_CHAR_BYTES-1:0]    head_res;
  logic                         q_pop;
  res_t                         out_res;

  assign accept = in_push && !in_full;

  uss_front #(
    .MAX_CHAR_BYTES(MAX_CHAR_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_eos   (in_end_of_string),
    .ent_push (ent_push),
    .ent_cnt  (ent_cnt),
    .ent_res  (ent_res)
  );

  uss_queue #(
    .NRES(MAX_CHAR_BYTES)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ent_push),
    .push_cnt   (ent_cnt),
    .push_res   (ent_res),
    .full       (in_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cnt   (head_cnt),
    .head_res   (head_res)
  );

  uss_back #(
    .NRES(MAX_CHAR_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cnt   (head_cnt),
    .head_res   (head_res),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_res    (out_res)
  );

  assign out_byte         = out_res.data;
  assign out_byte_valid   = out_res.valid;
  assign out_token_start  = out_res.tok_start;
  assign out_sentence_end = out_res.sent_end;
  assign out_string_done  = out_res.str_done;
  assign out_bad_utf8     = out_res.bad;

endmodule

### design/uss_front.sv
// front end: classifies each byte, tracks tokens and builds result groups
`timescale 1ns / 1ps

module uss_front #(
  parameter int MAX_CHAR_BYTES = 6
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic [7:0]                             in_byte,
  input  logic                                   in_eos,
  output logic                                   ent_push,
  output logic [$clog2(MAX_CHAR_BYTES):0]        ent_cnt,
  output uss_pkg::res_t [MAX_CHAR_BYTES-1:0]     ent_res
);
  import uss_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHAR_BYTES);
  localparam int CNT_W = IDX_W + 1;

  logic [2:0]       exp_r, exp_nxt;
  logic [IDX_W-1:0] held_r, held_nxt;
  logic [7:0]       hb_r, hb_nxt;
  logic             hv_r, hv_nxt;
  logic             long_r, long_nxt;
  logic             skip_r, skip_nxt;
  logic             open_r, open_nxt;
  logic [7:0]       cb_r [MAX_CHAR_BYTES];
  logic             cb_we;
  logic [IDX_W-1:0] cb_idx;

  always_comb begin
    logic       lone;
    logic       se_flush;
    logic       open_flush;
    logic       done;
    logic       punct;
    logic       bad_lead;
    logic [2:0] len;
    res_t       flush_res;
    res_t       stat_res;
    res_t       tail_res;

    exp_nxt  = exp_r;
    held_nxt = held_r;
    hb_nxt   = hb_r;
    hv_nxt   = hv_r;
    long_nxt = long_r;
    skip_nxt = skip_r;
    open_nxt = open_r;
    ent_cnt  = '0;
    ent_res  = '0;
    cb_we    = 1'b0;
    cb_idx   = held_r;

    lone       = !long_r;
    se_flush   = hv_r && lone && (hb_r == CH_QMARK || hb_r == CH_EXCL);
    open_flush = open_r && !se_flush;
    len        = lead_len(in_byte);
    bad_lead   = (len == 3'd0) || (int'(len) > MAX_CHAR_BYTES);
    done       = (CNT_W'(held_r) + CNT_W'(1)) >= CNT_W'(exp_r);
    punct      = (exp_r == 3'd3) && is_punct(cb_r[0], cb_r[1], in_byte);
    flush_res  = res_t'{data: hb_r, valid: 1'b1, tok_start: lone, sent_end: se_flush,
                        str_done: 1'b0, bad: 1'b0};
    stat_res   = res_t'{data: 8'h00, valid: 1'b0, tok_start: 1'b0, sent_end: open_r,
                        str_done: 1'b1, bad: 1'b1};
    tail_res   = res_t'{data: in_byte, valid: 1'b1, tok_start: !hv_r, sent_end: 1'b1,
                        str_done: 1'b1, bad: 1'b0};

    if (skip_r) begin
      if (in_eos) begin
        skip_nxt = 1'b0;
      end
    end else if (exp_r != 3'd0) begin
      cb_we = 1'b1;
      if (done) begin
        for (int k = 0; k < MAX_CHAR_BYTES; k++) begin
          ent_res[k].data      = (IDX_W'(k) == held_r) ? in_byte : cb_r[k];
          ent_res[k].valid     = 1'b1;
          ent_res[k].tok_start = (k == 0);
          ent_res[k].sent_end  = (CNT_W'(k + 1) == CNT_W'(exp_r)) && (punct || in_eos);
          ent_res[k].str_done  = (CNT_W'(k + 1) == CNT_W'(exp_r)) && in_eos;
          ent_res[k].bad       = 1'b0;
        end
        ent_cnt  = CNT_W'(exp_r);
        open_nxt = !punct && !in_eos;
        exp_nxt  = 3'd0;
        held_nxt = '0;
      end else begin
        held_nxt = held_r + IDX_W'(1);
        if (in_eos) begin
          // string cut inside a character: drop its bytes and push a status beat
          ent_res[0] = stat_res;
          ent_cnt    = CNT_W'(1);
          exp_nxt    = 3'd0;
          held_nxt   = '0;
          open_nxt   = 1'b0;
        end
      end
    end else if (!in_byte[7]) begin
      if (in_byte == CH_SPACE) begin
        if (hv_r) begin
          ent_res[0] = flush_res;
          ent_res[1] = res_t'{data: CH_SPACE, valid: 1'b1, tok_start: 1'b1,
                              sent_end: in_eos, str_done: in_eos, bad: 1'b0};
          ent_cnt    = CNT_W'(2);
        end else begin
          ent_res[0] = res_t'{data: CH_SPACE, valid: 1'b1, tok_start: 1'b1,
                              sent_end: in_eos, str_done: in_eos, bad: 1'b0};
          ent_cnt    = CNT_W'(1);
        end
        hv_nxt   = 1'b0;
        long_nxt = 1'b0;
        open_nxt = !in_eos;
      end else begin
        // a run byte is held until the next byte shows whether the run goes on
        if (hv_r) begin
          ent_res[0] = res_t'{data: hb_r, valid: 1'b1, tok_start: lone,
                              sent_end: 1'b0, str_done: 1'b0, bad: 1'b0};
          ent_res[1] = tail_res;
          ent_cnt    = in_eos ? CNT_W'(2) : CNT_W'(1);
        end else begin
          ent_res[0] = tail_res;
          ent_cnt    = in_eos ? CNT_W'(1) : CNT_W'(0);
        end
        if (in_eos) begin
          hv_nxt   = 1'b0;
          long_nxt = 1'b0;
          open_nxt = 1'b0;
        end else begin
          hv_nxt   = 1'b1;
          long_nxt = hv_r;
          hb_nxt   = in_byte;
          open_nxt = 1'b1;
        end
      end
    end else begin
      stat_res.sent_end = open_flush;
      if (hv_r) begin
        ent_res[0] = flush_res;
      end
      if (bad_lead || in_eos) begin
        if (hv_r) begin
          ent_res[1] = stat_res;
        end else begin
          ent_res[0] = stat_res;
        end
        ent_cnt  = hv_r ? CNT_W'(2) : CNT_W'(1);
        open_nxt = 1'b0;
        skip_nxt = bad_lead && !in_eos;
      end else begin
        ent_cnt  = hv_r ? CNT_W'(1) : CNT_W'(0);
        exp_nxt  = len;
        held_nxt = IDX_W'(1);
        open_nxt = open_flush;
        cb_we    = 1'b1;
        cb_idx   = '0;
      end
      hv_nxt   = 1'b0;
      long_nxt = 1'b0;
    end

    ent_push = accept && (ent_cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= 3'd0;
      held_r <= '0;
      hb_r   <= 8'h00;
      hv_r   <= 1'b0;
      long_r <= 1'b0;
      skip_r <= 1'b0;
      open_r <= 1'b0;
    end else if (accept) begin
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
      hb_r   <= hb_nxt;
      hv_r   <= hv_nxt;
      long_r <= long_nxt;
      skip_r <= skip_nxt;
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cb_we) begin
      cb_r[cb_idx] <= in_byte;
    end
  end

endmodule

### design/uss_queue.sv
// short queue of result groups between the front end and the output side
`timescale 1ns / 1ps

module uss_queue #(
  parameter int NRES = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [$clog2(NRES):0]         push_cnt,
  input  uss_pkg::res_t [NRES-1:0]      push_res,
  output logic                          full,
  input  logic                          pop,
  output logic                          head_valid,
  output logic [$clog2(NRES):0]         head_cnt,
  output uss_pkg::res_t [NRES-1:0]      head_res
);
  import uss_pkg::*;

  localparam int CNT_W = $clog2(NRES) + 1;
  localparam int PTR_W = $clog2(QDEPTH);

  logic [CNT_W-1:0]  cnt_mem_r [QDEPTH];
  res_t [NRES-1:0]   res_mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    fill_r, fill_nxt;
  logic              do_pop;

  assign full       = (fill_r == (PTR_W + 1)'(QDEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cnt   = cnt_mem_r[rd_ptr_r];
  assign head_res   = res_mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cnt_mem_r[wr_ptr_r] <= push_cnt;
      res_mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

### design/uss_back.sv
// output side: walks each result group one beat at a time into the output register
`timescale 1ns / 1ps
`include "utf8_sentence_splitter_macros.svh"

module uss_back #(
  parameter int NRES = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  logic [$clog2(NRES):0]         head_cnt,
  input  uss_pkg::res_t [NRES-1:0]      head_res,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output uss_pkg::res_t                 out_res
);
  import uss_pkg::*;

  localparam int IDX_W = $clog2(NRES);
  localparam int CNT_W = IDX_W + 1;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  res_t             out_r, out_nxt;
  logic             out_v_r, out_v_nxt;
  logic             load;
  logic             last;

  assign load      = !out_v_r || out_pop;
  assign last      = (CNT_W'(idx_r) + CNT_W'(1)) == head_cnt;
  assign q_pop     = load && head_valid && last;
  assign out_empty = !out_v_r;
  assign out_res   = out_r;

  always_comb begin
    idx_nxt   = idx_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = head_valid;
      if (head_valid) begin
        out_nxt = head_res[idx_r];
        idx_nxt = last ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // a bare status beat always reports bad utf8 and the end of the string
  `USS_ASSERT_IMPL(a_status_is_bad, out_v_r && !out_r.valid, out_r.bad && out_r.str_done)
  // the beat index never runs past the group at the head
  `USS_ASSERT_IMPL(a_idx_in_group, head_valid, CNT_W'(idx_r) < head_cnt)
  // finishing a group restarts the walk at its first beat
  `USS_ASSERT_NEXT(a_pop_restarts, q_pop, idx_r == '0)

endmodule
